// ===== hw/rtl/pcf_pkg.sv =====
package pcf_pkg;

    // Sizes of the line store and of the pixel word.
    localparam int MAX_COLS   = 1024;
    localparam int PIXEL_BITS = 30;

    // Column index and column count widths follow from the line length.
    localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int COL_CNT_W = $clog2(MAX_COLS + 1);

    // Fixed field widths of the configuration registers.
    localparam int COLS_CFG_W = 11;
    localparam int ROW_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // Column count after reset, clamped to the line length.
    localparam int COLS_RESET_INT = (MAX_COLS < 1024) ? MAX_COLS : 1024;
    localparam logic [COL_CNT_W-1:0] COLS_RESET = COL_CNT_W'(COLS_RESET_INT);

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = CFG_IDX_W'(1);

    // Request types.
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef logic [PIXEL_BITS-1:0] pixel_t;
    typedef logic [COL_W-1:0]      col_t;

    // One entry of the line store: the row two above and the row just above.
    typedef struct packed {
        pixel_t upper;
        pixel_t center;
    } line_word_t;

    // Work handed from the sequencer to the judging stage for one word.
    typedef struct packed {
        logic   live;
        logic   produce;
        logic   wr_en;
        logic   left_en;
        logic   right_en;
        logic   up_en;
        logic   frame_end;
        col_t   col;
        pixel_t pixel;
    } cmd_t;

endpackage

// ===== hw/rtl/pcf_line_mem.sv =====
module pcf_line_mem (
    input  logic                clk,
    input  logic                rd_en,
    input  pcf_pkg::col_t       rd_addr_a,
    input  pcf_pkg::col_t       rd_addr_b,
    output pcf_pkg::line_word_t rd_data_a,
    output pcf_pkg::line_word_t rd_data_b,
    input  logic                wr_en,
    input  pcf_pkg::col_t       wr_addr,
    input  pcf_pkg::line_word_t wr_data
);
    import pcf_pkg::*;

    line_word_t mem [MAX_COLS];
    line_word_t rd_a_reg;
    line_word_t rd_b_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two read ports; data holds while no new read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ===== hw/rtl/pcf_seq.sv =====
module pcf_seq (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pcf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             accept,
    input  logic                             req_type,
    input  pcf_pkg::pixel_t                  pixel_in,
    output pcf_pkg::cmd_t                    cmd
);
    import pcf_pkg::*;

    logic [COL_CNT_W-1:0]  cols_reg;
    logic [ROW_W-1:0]      rows_reg;
    col_t                  in_col_reg;
    col_t                  in_col_next;
    logic [ROW_W-1:0]      in_row_reg;
    logic [ROW_W-1:0]      in_row_next;
    col_t                  out_col_reg;
    col_t                  out_col_next;
    logic [ROW_W-1:0]      out_row_reg;
    logic [ROW_W-1:0]      out_row_next;

    logic                  frame_done;
    logic [ROW_W-1:0]      pix_row;
    col_t                  pix_col;
    col_t                  base_ocol;
    logic [ROW_W-1:0]      base_orow;
    col_t                  sel_col;
    logic [COL_CNT_W-1:0]  sel_col_plus;
    logic                  sel_col_last;
    logic [COL_CNT_W-1:0]  ocol_plus;
    logic                  flush_ok;
    logic [COLS_CFG_W-1:0] cols_raw;
    logic [COL_CNT_W-1:0]  cols_eff;
    logic [ROW_W-1:0]      rows_eff;

    // Effective register values: zero counts as one, wide rows clamp to the line.
    always_comb
    begin
        cols_raw = cfg_data[COLS_CFG_W-1:0];
        if (cols_raw == '0)
        begin
            cols_eff = COL_CNT_W'(1);
        end
        else if (int'(cols_raw) > MAX_COLS)
        begin
            cols_eff = COL_CNT_W'(MAX_COLS);
        end
        else
        begin
            cols_eff = COL_CNT_W'(cols_raw);
        end
        rows_eff = (cfg_data[ROW_W-1:0] == '0) ? ROW_W'(1) : cfg_data[ROW_W-1:0];
    end

    // Position of the word being accepted and classification of the request.
    always_comb
    begin
        frame_done   = (in_row_reg >= rows_reg);
        pix_row      = frame_done ? '0 : in_row_reg;
        pix_col      = frame_done ? '0 : in_col_reg;
        base_ocol    = frame_done ? '0 : out_col_reg;
        base_orow    = frame_done ? '0 : out_row_reg;
        flush_ok     = frame_done && (out_row_reg < rows_reg);
        sel_col      = (req_type == REQ_FLUSH) ? out_col_reg : pix_col;
        sel_col_plus = COL_CNT_W'(sel_col) + COL_CNT_W'(1);
        sel_col_last = (sel_col_plus >= cols_reg);

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        ocol_plus    = '0;
        cmd          = '0;

        if (req_type == REQ_PIXEL)
        begin
            cmd.live     = 1'b1;
            cmd.wr_en    = 1'b1;
            cmd.produce  = (pix_row != '0);
            cmd.up_en    = (pix_row >= ROW_W'(2));
            cmd.left_en  = (pix_col != '0);
            cmd.right_en = !sel_col_last;
            cmd.col      = pix_col;
            cmd.pixel    = pixel_in;

            // Input position advances over the row.
            if (sel_col_last)
            begin
                in_col_next = '0;
                in_row_next = pix_row + ROW_W'(1);
            end
            else
            begin
                in_col_next = sel_col_plus[COL_W-1:0];
                in_row_next = pix_row;
            end

            // Output position advances when the row above gets a result.
            out_col_next = base_ocol;
            out_row_next = base_orow;
            if (pix_row != '0)
            begin
                ocol_plus = COL_CNT_W'(base_ocol) + COL_CNT_W'(1);
                if (ocol_plus >= cols_reg)
                begin
                    out_col_next = '0;
                    out_row_next = base_orow + ROW_W'(1);
                end
                else
                begin
                    out_col_next = ocol_plus[COL_W-1:0];
                end
            end
        end
        else if (flush_ok)
        begin
            cmd.live      = 1'b1;
            cmd.produce   = 1'b1;
            cmd.up_en     = (out_row_reg != '0);
            cmd.left_en   = (out_col_reg != '0);
            cmd.right_en  = !sel_col_last;
            cmd.frame_end = sel_col_last;
            cmd.col       = out_col_reg;
            if (sel_col_last)
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + ROW_W'(1);
            end
            else
            begin
                out_col_next = sel_col_plus[COL_W-1:0];
            end
        end
    end

    // Frame geometry and position counters; any register write restarts the frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg    <= COLS_RESET;
            rows_reg    <= ROW_W'(1);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_COLS:
                begin
                    cols_reg    <= cols_eff;
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end
                REG_FRAME_ROWS:
                begin
                    rows_reg    <= rows_eff;
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule

// ===== hw/rtl/pcf_judge.sv =====
module pcf_judge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  pcf_pkg::cmd_t       cmd_in,
    output logic                busy,
    output logic                rd_en,
    output pcf_pkg::col_t       rd_addr_a,
    output pcf_pkg::col_t       rd_addr_b,
    input  pcf_pkg::line_word_t rd_data_a,
    input  pcf_pkg::line_word_t rd_data_b,
    output logic                wr_en,
    output pcf_pkg::col_t       wr_addr,
    output pcf_pkg::line_word_t wr_data,
    output logic                dst_valid,
    input  logic                dst_stall,
    output pcf_pkg::pixel_t     pixel_out,
    output logic                frame_end
);
    import pcf_pkg::*;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    cmd_t       s1_cmd_reg;
    logic       byp_a_reg;
    logic       byp_b_reg;
    line_word_t byp_word_reg;
    pixel_t     left_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    pixel_t     out_pixel_reg;
    logic       out_end_reg;

    logic       out_free;
    logic       s1_adv;
    logic       s1_emit;
    pixel_t     center;
    pixel_t     up_raw;
    pixel_t     right_raw;
    pixel_t     left_tap;
    pixel_t     right_tap;
    pixel_t     up_tap;
    pixel_t     down_tap;
    pixel_t     max_lr;
    pixel_t     max_ud;
    pixel_t     best;
    pixel_t     result;

    // Stage handshake: the judging stage moves on when its result, if any, has a place.
    assign out_free = !out_valid_reg || !dst_stall;
    assign s1_adv   = s1_valid_reg && (!s1_cmd_reg.produce || out_free);
    assign s1_emit  = s1_adv && s1_cmd_reg.produce;
    assign busy     = s1_valid_reg && !s1_adv;

    // Reads for the accepted word: its own column and the one to the right.
    assign rd_en     = accept;
    assign rd_addr_a = cmd_in.col;
    assign rd_addr_b = cmd_in.col + COL_W'(1);

    // Taps, with the word written in the read cycle forwarded over stale data.
    always_comb
    begin
        center    = byp_a_reg ? byp_word_reg.center : rd_data_a.center;
        up_raw    = byp_a_reg ? byp_word_reg.upper : rd_data_a.upper;
        right_raw = byp_b_reg ? byp_word_reg.center : rd_data_b.center;
        left_tap  = s1_cmd_reg.left_en ? left_reg : '0;
        right_tap = s1_cmd_reg.right_en ? right_raw : '0;
        up_tap    = s1_cmd_reg.up_en ? up_raw : '0;
        down_tap  = s1_cmd_reg.pixel;
        max_lr    = (left_tap > right_tap) ? left_tap : right_tap;
        max_ud    = (up_tap > down_tap) ? up_tap : down_tap;
        best      = (max_lr > max_ud) ? max_lr : max_ud;
        result    = (center > best) ? best : center;
    end

    // Write-back: the row above moves up, the new pixel becomes the row above.
    assign wr_en          = s1_adv && s1_cmd_reg.wr_en;
    assign wr_addr        = s1_cmd_reg.col;
    assign wr_data.upper  = center;
    assign wr_data.center = s1_cmd_reg.pixel;

    // Occupancy of the judging stage and of the result register.
    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = cmd_in.live;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!dst_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage payload and forwarding flags, captured with the memory read.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg   <= cmd_in;
            byp_a_reg    <= wr_en && (wr_addr == rd_addr_a);
            byp_b_reg    <= wr_en && (wr_addr == rd_addr_b);
            byp_word_reg <= wr_data;
        end
        if (s1_adv)
        begin
            left_reg <= center;
        end
        if (s1_emit)
        begin
            out_pixel_reg <= result;
            out_end_reg   <= s1_cmd_reg.frame_end;
        end
    end

    assign dst_valid = out_valid_reg;
    assign pixel_out = out_pixel_reg;
    assign frame_end = out_end_reg;

endmodule

// ===== hw/rtl/peak_clamp_cross_filter.sv =====
// The accepting edge loads a word into the judging stage; its result is then registered onto
// dst_valid. Pixel (r,c) is caused by pixel (r+1,c), last-row pixels by flush words.
// Throughput: one word per cycle, set by the two-read, one-write line store, barring stalls.
// Reset (rst_n, asynchronous, active low) clears the pipeline and position counters
// and sets 1024 columns by 1 row; the line store is not cleared and needs no pass.
module peak_clamp_cross_filter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pcf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pcf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           src_valid,
    output logic                           src_stall,
    input  logic                           req_type,
    input  pcf_pkg::pixel_t                pixel_in,
    output logic                           dst_valid,
    input  logic                           dst_stall,
    output pcf_pkg::pixel_t                pixel_out,
    output logic                           frame_end
);
    import pcf_pkg::*;

    logic       accept;
    cmd_t       cmd;
    logic       rd_en;
    col_t       rd_addr_a;
    col_t       rd_addr_b;
    line_word_t rd_data_a;
    line_word_t rd_data_b;
    logic       wr_en;
    col_t       wr_addr;
    line_word_t wr_data;
    logic       busy;

    // A word is taken whenever the judging stage can move.
    assign src_stall = busy;
    assign accept    = src_valid && !src_stall;

    pcf_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .req_type  (req_type),
        .pixel_in  (pixel_in),
        .cmd       (cmd)
    );

    pcf_line_mem u_line_mem (
        .clk       (clk),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    pcf_judge u_judge (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd_in    (cmd),
        .busy      (busy),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .pixel_out (pixel_out),
        .frame_end (frame_end)
    );

endmodule

// ===== sim/testbench.sv =====
module testbench;

    import pcf_pkg::*;

    localparam pixel_t PIX_MAX = '1;
    localparam int SETTLE = 6;
    localparam int RANDOM_WORDS = 800;

    typedef enum logic {STEP_CFG, STEP_WORD} step_kind_e;
    typedef enum int {PIX_WIDE, PIX_TIES, PIX_PEAKS} pixel_style_e;
    typedef enum int {RX_OPEN, RX_COIN, RX_EVERY, RX_HEAVY} rx_mode_e;

    // One row of the directed plan: a register write or a word, with an optional
    // result typed in by hand.
    typedef struct packed {
        step_kind_e            kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  req;
        pixel_t                px;
        logic                  typed;
        pixel_t                want_px;
        logic                  want_end;
    } plan_row_t;

    typedef struct {
        pixel_t value;
        logic   last;
    } filtered_t;

    localparam int PLAN_LEN = 27;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // 1x1 frame: any pixel filters to zero, flushes beyond the frame do nothing.
        '{STEP_CFG,  REG_FRAME_COLS, 16'd0, REQ_PIXEL, 30'd0,   1'b0, 30'd0, 1'b0},
        '{STEP_CFG,  REG_FRAME_ROWS, 16'd0, REQ_PIXEL, 30'd0,   1'b0, 30'd0, 1'b0},
        '{STEP_WORD, REG_FRAME_COLS, 16'd0, REQ_FLUSH, 30'd0,   1'b0, 30'd0, 1'b0},
        '{STEP_WORD, REG_FRAME_COLS, 16'd0, REQ_PIXEL, PIX_MAX, 1'b0, 30'd0, 1'b0},
        '{STEP_WORD, REG_FRAME_COLS, 16'd0, REQ_FLUSH, 30'd0,   1'b1, 30'd0, 1'b1},
        '{STEP_WORD, REG_FRAME_COLS, 16'd0, REQ_FLUSH, PIX_MAX, 1'b0, 30'd0, 1'b0},
        '{STEP_WORD, REG_FRAME_COLS, 16'd0, REQ_PIXEL, 30'd5,   1'b0, 30'd0, 1'b0},
        '{STEP_WORD, REG_FRAME_COLS, 16'd0, REQ_FLUSH, 30'd0,   1'b1, 30'd0, 1'b1},
        // 3x2 frame with a full-scale peak in the top row.
        '{STEP_CFG,  REG_FRAME_COLS, 16'd3, REQ_PIXEL, 30'd0,   1'b0, 30'd0, 1'b0},
        '{STEP_CFG,  REG_FRAME_ROWS, 16'd2, REQ_PIXEL, 30'd0,   1'b0, 30'd0, 1'b0},
        '{STEP_WORD, REG_FRAME_COLS, 16'd0, REQ_PIXEL, 30'd0,   1'b0, 30'd0, 1'b0},
        '{STEP_WORD, REG_FRAME_COLS, 16'd0, REQ_PIXEL, PIX_MAX, 1'b0, 30'd0, 1'b0},
        '{STEP_WORD, REG_FRAME_COLS, 16'd0, REQ_FLUSH, 30'd0,   1'b0, 30'd0, 1'b0},
        '{STEP_WORD, REG_FRAME_COLS, 16'd0, REQ_PIXEL, 30'd0,   1'b0, 30'd0, 1'b0},
        '{STEP_WORD, REG_FRAME_COLS, 16'd0, REQ_PIXEL, 30'd7,   1'b1, 30'd0, 1'b0},
        '{STEP_WORD, REG_FRAME_COLS, 16'd0, REQ_PIXEL, 30'd1,   1'b1, 30'd1, 1'b0},
        '{STEP_WORD, REG_FRAME_COLS, 16'd0, REQ_PIXEL, 30'd9,   1'b1, 30'd0, 1'b0},
        '{STEP_WORD, REG_FRAME_COLS, 16'd0, REQ_FLUSH, 30'd0,   1'b0, 30'd0, 1'b0},
        '{STEP_WORD, REG_FRAME_COLS, 16'd0, REQ_FLUSH, 30'd0,   1'b0, 30'd0, 1'b0},
        // A pixel here abandons the last undrained output.
        '{STEP_WORD, REG_FRAME_COLS, 16'd0, REQ_PIXEL, 30'd4,   1'b0, 30'd0, 1'b0},
        // Equal neighbours are not a strict peak and pass unchanged.
        '{STEP_CFG,  REG_FRAME_COLS, 16'd2, REQ_PIXEL, 30'd0,   1'b0, 30'd0, 1'b0},
        '{STEP_CFG,  REG_FRAME_ROWS, 16'd1, REQ_PIXEL, 30'd0,   1'b0, 30'd0, 1'b0},
        '{STEP_WORD, REG_FRAME_COLS, 16'd0, REQ_PIXEL, 30'd6,   1'b0, 30'd0, 1'b0},
        '{STEP_WORD, REG_FRAME_COLS, 16'd0, REQ_PIXEL, 30'd6,   1'b0, 30'd0, 1'b0},
        '{STEP_WORD, REG_FRAME_COLS, 16'd0, REQ_FLUSH, 30'd0,   1'b1, 30'd6, 1'b0},
        '{STEP_WORD, REG_FRAME_COLS, 16'd0, REQ_FLUSH, 30'd0,   1'b1, 30'd6, 1'b1},
        '{STEP_WORD, REG_FRAME_COLS, 16'd0, REQ_FLUSH, 30'd0,   1'b0, 30'd0, 1'b0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  src_valid;
    logic                  src_stall;
    logic                  req_type;
    pixel_t                pixel_in;
    logic                  dst_valid;
    logic                  dst_stall;
    pixel_t                pixel_out;
    logic                  frame_end;

    // Filter state as the testbench sees it.
    pixel_t                 upper_row [MAX_COLS];
    pixel_t                 center_row [MAX_COLS];
    pixel_t                 left_tap;
    int unsigned            in_r, in_c, out_r, out_c;
    logic [COLS_CFG_W-1:0]  cols_reg;
    logic [ROW_W-1:0]       rows_reg;

    filtered_t   pending_pixels [$];
    int          mismatches;
    int          words_checked;
    int          burst_left;
    int unsigned useful_items;

    peak_clamp_cross_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .req_type  (req_type),
        .pixel_in  (pixel_in),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .pixel_out (pixel_out),
        .frame_end (frame_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("testbench NOT OK");
        $finish;
    end

    // Column count in effect: zero acts as one, anything past the line store is clipped.
    function automatic int unsigned cols_in_use(input logic [COLS_CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_COLS)
            return MAX_COLS;
        return v;
    endfunction

    // A pixel above every neighbour drops to the largest of them.
    function automatic pixel_t clamp_peak(input pixel_t mid, input pixel_t l, input pixel_t r,
                                          input pixel_t u, input pixel_t d);
        pixel_t best;
        best = l;
        if (r > best) best = r;
        if (u > best) best = u;
        if (d > best) best = d;
        return (mid > best) ? best : mid;
    endfunction

    function automatic void restart_positions();
        in_r = 0;
        in_c = 0;
        out_r = 0;
        out_c = 0;
    endfunction

    // Advance the filter state by one word; returns 1 when the word yields a pixel.
    function automatic bit clamp_next(input logic req, input pixel_t px,
                                      output pixel_t res, output logic last);
        int unsigned cols_eff;
        int unsigned rows_eff;
        int unsigned c;
        pixel_t      mid, l, r, u;
        bit          made;
        cols_eff = cols_in_use(cols_reg);
        rows_eff = (rows_reg == 0) ? 1 : rows_reg;
        made = 1'b0;
        res = '0;
        last = 1'b0;
        if (req == REQ_FLUSH)
        begin
            // Drain one last-row pixel, only while the frame is complete.
            if (in_r >= rows_eff && out_r < rows_eff)
            begin
                c = (out_c >= cols_eff) ? cols_eff - 1 : out_c;
                mid = center_row[c];
                l = (c > 0) ? center_row[c - 1] : '0;
                r = (c + 1 < cols_eff) ? center_row[c + 1] : '0;
                u = (out_r >= 1) ? upper_row[c] : '0;
                res = clamp_peak(mid, l, r, u, '0);
                last = (c == cols_eff - 1);
                left_tap = l;
                out_c++;
                if (out_c >= cols_eff)
                begin
                    out_c = 0;
                    out_r++;
                end
                made = 1'b1;
            end
        end
        else
        begin
            if (in_r >= rows_eff)
                restart_positions();
            c = (in_c >= cols_eff) ? cols_eff - 1 : in_c;
            mid = center_row[c];
            // The incoming pixel is the lower neighbour of the row above.
            if (in_r >= 1)
            begin
                l = (c > 0) ? left_tap : '0;
                r = (c + 1 < cols_eff) ? center_row[c + 1] : '0;
                u = (in_r >= 2) ? upper_row[c] : '0;
                res = clamp_peak(mid, l, r, u, px);
                out_c++;
                if (out_c >= cols_eff)
                begin
                    out_c = 0;
                    out_r++;
                end
                made = 1'b1;
            end
            left_tap = mid;
            upper_row[c] = mid;
            center_row[c] = px;
            in_c = c + 1;
            if (in_c >= cols_eff)
            begin
                in_c = 0;
                in_r = in_r + 1;
            end
        end
        return made;
    endfunction

    function automatic pixel_t pick_pixel(input pixel_style_e style);
        case (style)
            PIX_TIES:  return pixel_t'($urandom_range(0, 3));
            PIX_PEAKS:
            begin
                if ($urandom_range(0, 9) == 0)
                    return ($urandom_range(0, 1) == 0) ? PIX_MAX : pixel_t'($urandom);
                return pixel_t'($urandom_range(0, 1000));
            end
            default:
            begin
                if ($urandom_range(0, 15) == 0)
                    return ($urandom_range(0, 1) == 0) ? PIX_MAX : '0;
                return pixel_t'($urandom);
            end
        endcase
    endfunction

    // Register write, only once every expected pixel has come out.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        src_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_FRAME_COLS)
            cols_reg = data[COLS_CFG_W-1:0];
        else if (idx == REG_FRAME_ROWS)
            rows_reg = data[ROW_W-1:0];
        restart_positions();
        burst_left = 0;
    endtask

    // Offer one word in bursts with random gaps, then predict what it yields.
    task automatic send_word(input logic req, input pixel_t px, input logic typed,
                             input pixel_t want_px, input logic want_end);
        pixel_t got;
        logic   got_end;
        bit     made;
        int     gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap != 0)
            begin
                src_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        src_valid <= 1'b1;
        req_type <= req;
        pixel_in <= px;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        made = clamp_next(req, px, got, got_end);
        if (typed)
            pending_pixels.push_back('{want_px, want_end});
        else if (made)
            pending_pixels.push_back('{got, got_end});
        if (req == REQ_PIXEL || made)
            useful_items++;
        @(negedge clk);
    endtask

    // One phase of small random frames, mostly well formed.
    task automatic random_phase();
        int unsigned cols_v, rows_v, frames, cols_eff, rows_eff, total, cut, flushes, k;
        int unsigned pick;
        pixel_style_e style;
        pick = $urandom_range(0, 19);
        cols_v = (pick == 0) ? 0 : (pick < 3) ? $urandom_range(9, 48) : $urandom_range(1, 8);
        pick = $urandom_range(0, 19);
        rows_v = (pick == 0) ? 0 : $urandom_range(1, 6);
        pick = $urandom_range(0, 3);
        // Upper data bits beyond the column field are don't-care.
        if (pick != 1 || cols_in_use(cols_reg) > 48)
            write_register(REG_FRAME_COLS,
                           {5'($urandom_range(0, 31)), COLS_CFG_W'(cols_v)});
        if (pick != 0 || rows_reg > 8)
            write_register(REG_FRAME_ROWS, CFG_DATA_W'(rows_v));
        cols_eff = cols_in_use(cols_reg);
        rows_eff = (rows_reg == 0) ? 1 : rows_reg;
        frames = $urandom_range(1, 3);
        repeat (frames)
        begin
            style = pixel_style_e'($urandom_range(0, 2));
            total = cols_eff * rows_eff;
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, total - 1) : total;
            for (k = 0; k < cut; k++)
            begin
                if ($urandom_range(0, 39) == 0)
                    send_word(REQ_FLUSH, pixel_t'($urandom), 1'b0, '0, 1'b0);
                send_word(REQ_PIXEL, pick_pixel(style), 1'b0, '0, 1'b0);
            end
            pick = $urandom_range(0, 7);
            flushes = (pick == 0) ? $urandom_range(0, cols_eff - 1) :
                      (pick == 1) ? cols_eff + $urandom_range(1, 3) : cols_eff;
            repeat (flushes) send_word(REQ_FLUSH, pixel_t'($urandom), 1'b0, '0, 1'b0);
        end
    endtask

    // Receiver: stall patterns in segments, plus two long hold-offs.
    initial
    begin
        rx_mode_e mode;
        int seg_left, hold_left, holds_done, period, cyc;
        dst_stall = 1'b0;
        mode = RX_OPEN;
        seg_left = 0;
        hold_left = 0;
        holds_done = 0;
        period = 2;
        cyc = 0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (hold_left == 0 && holds_done < 2 &&
                words_checked >= ((holds_done == 0) ? 150 : 1200))
            begin
                hold_left = 400;
                holds_done++;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                dst_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode = rx_mode_e'($urandom_range(0, 3));
                    seg_left = $urandom_range(10, 150);
                    period = $urandom_range(2, 6);
                end
                seg_left--;
                case (mode)
                    RX_OPEN:  dst_stall <= 1'b0;
                    RX_COIN:  dst_stall <= 1'($urandom_range(0, 1));
                    RX_EVERY: dst_stall <= (cyc % period == 0);
                    default:  dst_stall <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Compare every word leaving the block with the oldest expected pixel.
    always @(posedge clk)
    begin
        filtered_t want;
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: pixel_out=%h frame_end=%b",
                             pixel_out, frame_end);
            end
            else
            begin
                want = pending_pixels.pop_front();
                words_checked++;
                if (want.value !== pixel_out || want.last !== frame_end)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d: expected pixel_out=%h frame_end=%b, got %h %b",
                                 words_checked, want.value, want.last, pixel_out, frame_end);
                end
            end
        end
    end

    // Main sequence: reset, directed plan, wide-row phases, then random phases.
    initial
    begin
        int i;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        src_valid = 1'b0;
        req_type = REQ_PIXEL;
        pixel_in = '0;
        mismatches = 0;
        words_checked = 0;
        burst_left = 0;
        useful_items = 0;
        foreach (upper_row[j])
        begin
            upper_row[j] = '0;
            center_row[j] = '0;
        end
        left_tap = '0;
        restart_positions();
        cols_reg = COLS_CFG_W'(1024);
        rows_reg = 1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < PLAN_LEN; i++)
        begin
            if (PLAN[i].kind == STEP_CFG)
                write_register(PLAN[i].idx, PLAN[i].data);
            else
                send_word(PLAN[i].req, PLAN[i].px, PLAN[i].typed,
                          PLAN[i].want_px, PLAN[i].want_end);
        end

        // Full-width rows: one complete row, then part of the second.
        write_register(REG_FRAME_COLS, CFG_DATA_W'(MAX_COLS));
        write_register(REG_FRAME_ROWS, 16'd2);
        repeat (MAX_COLS + 48) send_word(REQ_PIXEL, pick_pixel(PIX_WIDE), 1'b0, '0, 1'b0);

        // Column count beyond the line store, abandoned partway.
        write_register(REG_FRAME_COLS, 16'd2047);
        write_register(REG_FRAME_ROWS, 16'd1);
        repeat (8) send_word(REQ_PIXEL, pick_pixel(PIX_WIDE), 1'b0, '0, 1'b0);
        repeat (2) send_word(REQ_FLUSH, '0, 1'b0, '0, 1'b0);

        // Largest row count, only the first few rows sent.
        write_register(REG_FRAME_COLS, 16'd2);
        write_register(REG_FRAME_ROWS, 16'hFFFF);
        repeat (20) send_word(REQ_PIXEL, pick_pixel(PIX_PEAKS), 1'b0, '0, 1'b0);

        useful_items = 0;
        while (useful_items < RANDOM_WORDS)
            random_phase();

        src_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE * 2) @(negedge clk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/pcf_pkg.sv
hw/rtl/pcf_line_mem.sv
hw/rtl/pcf_seq.sv
hw/rtl/pcf_judge.sv
hw/rtl/peak_clamp_cross_filter.sv
sim/testbench.sv
